// File: rtl/core/eph_pkg.sv
`default_nettype none

package eph_pkg;

  // Sequencer states: a clearing pass after reset, then one item at a time.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIN,
    ST_CLAMP,
    ST_ADDR,
    ST_UPDATE
  } eph_state_e;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THICK_Y_LO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THICK_Y_HI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THIN_Y_LO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THIN_Y_HI  = 3'd4;

  // Function and table codes
  localparam logic FUNC_EVENT = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam int TBL_W = 2;
  localparam logic [TBL_W-1:0] TBL_DEPTH = 2'd0;
  localparam logic [TBL_W-1:0] TBL_THICK = 2'd1;
  localparam logic [TBL_W-1:0] TBL_THIN  = 2'd2;

  // Positions are signed with 8 fraction bits (1/256 cm)
  localparam int POS_W = 14;
  localparam logic signed [POS_W-1:0] XZ_LIM = 14'sd512;   // 2 cm
  localparam logic signed [POS_W-1:0] Y_LIM  = 14'sd2560;  // 10 cm

  // Depth: bin = floor(N*(2560-y)/5120) = floor(floor(N*(2560-y)/1024)/5)
  localparam int DD_W        = 13;
  localparam int DEPTH_SHIFT = 10;

  // Slice: bin = floor(n*(p+1280)/2560) = floor(floor(n*(p+1280)/512)/5)
  localparam int SLICE_OFS   = 1280;
  localparam int SLICE_SHIFT = 9;

  // Quotient by five through a reciprocal, exact for inputs below 16384
  localparam int DIV_W = 14;
  localparam logic [14:0] DIV5_MUL = 15'd13108;

  function automatic logic [DIV_W-1:0] div5(input logic [DIV_W-1:0] v);
    logic [27:0] prod;
    prod = 28'(v) * 28'(DIV5_MUL);
    return DIV_W'(prod[27:16]);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/event_position_histogrammer.sv
// Event position histogrammer.
// Command channel: raise start_i with func_i and the payload; the item is taken
// at a rising edge where start_i is high and busy_o is low. func_i = 0 records
// an event (x, y, z in 1/256 cm) into a depth histogram and two XZ slice
// histograms; func_i = 1 reads one counter chosen by table_sel_i, row_index_i
// and col_index_i. Every item gives exactly one result, shown for one cycle
// with done_o high; the receiver cannot stall, so the result must be taken
// in that cycle.
// Sequencing: done_o rises in the same cycle in which busy_o is low again, so
// a new item is taken only after the previous one has given its result. The
// per-item sequence: bin arithmetic (constant multiply), clamp (reciprocal
// multiply), address and memory read (synchronous RAM), then the saturating
// increment and write-back.
// Reset: configuration returns to its defaults and a clearing pass zeroes all
// three counter memories, one entry a cycle, until the largest of them is
// cleared, while busy_o stays high. Configuration writes are taken at any
// time, but belong to idle periods.
`default_nettype none

module event_position_histogrammer #(
  parameter int DEPTH_BINS  = 200,
  parameter int THICK_BINS  = 10,
  parameter int THIN_BINS   = 50,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [eph_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [eph_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // command channel
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic                               func_i,
  input  wire logic signed [eph_pkg::POS_W-1:0]   pos_x_i,
  input  wire logic signed [eph_pkg::POS_W-1:0]   pos_y_i,
  input  wire logic signed [eph_pkg::POS_W-1:0]   pos_z_i,
  input  wire logic [eph_pkg::TBL_W-1:0]          table_sel_i,
  input  wire logic [7:0]                         row_index_i,
  input  wire logic [5:0]                         col_index_i,
  // result channel
  output logic                                    done_o,
  output logic                                    depth_hit_o,
  output logic [7:0]                              depth_bin_o,
  output logic                                    thick_hit_o,
  output logic                                    thin_hit_o,
  output logic [31:0]                             read_count_o
);

  localparam int THICK_SIZE = THICK_BINS * THICK_BINS;
  localparam int THIN_SIZE  = THIN_BINS * THIN_BINS;
  localparam int CLR_LEN0   = (DEPTH_BINS > THICK_SIZE) ? DEPTH_BINS : THICK_SIZE;
  localparam int CLR_LEN    = (CLR_LEN0 > THIN_SIZE) ? CLR_LEN0 : THIN_SIZE;
  localparam int CL_W       = $clog2(CLR_LEN + 1);

  localparam int DA_W = $clog2(DEPTH_BINS);
  localparam int KB_W = $clog2(THICK_BINS);
  localparam int KA_W = $clog2(THICK_SIZE);
  localparam int NB_W = $clog2(THIN_BINS);
  localparam int NA_W = $clog2(THIN_SIZE);

  localparam int DNUM_W = eph_pkg::DD_W + $clog2(DEPTH_BINS + 1);
  localparam int DV_W   = DNUM_W - eph_pkg::DEPTH_SHIFT;

  localparam int MAXN = (THICK_BINS > THIN_BINS) ? THICK_BINS : THIN_BINS;
  localparam int SN_W = eph_pkg::POS_W + 1 + $clog2(MAXN + 1) + 1;
  localparam int SV_W = SN_W - 1 - eph_pkg::SLICE_SHIFT;

  localparam int RC_W = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;

  // n * (p + 1280), signed
  function automatic logic signed [SN_W-1:0] slice_num(
    input logic signed [eph_pkg::POS_W-1:0] p,
    input int n
  );
    logic signed [SN_W-1:0] off;
    off = SN_W'(p) + SN_W'(eph_pkg::SLICE_OFS);
    return off * SN_W'(n);
  endfunction

  // divide the pre-shifted numerator by five and clamp to 0..n-1
  function automatic logic [eph_pkg::DIV_W-1:0] slice_bin(
    input logic            neg,
    input logic [SV_W-1:0] v,
    input int              n
  );
    logic [eph_pkg::DIV_W-1:0] q;
    q = eph_pkg::div5(eph_pkg::DIV_W'(v));
    if (neg) begin
      q = '0;
    end else if (q > eph_pkg::DIV_W'(n - 1)) begin
      q = eph_pkg::DIV_W'(n - 1);
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                               slice_en_q;
  logic signed [eph_pkg::POS_W-1:0]   thick_lo_q, thick_hi_q, thin_lo_q, thin_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_en_q <= 1'b1;
      thick_lo_q <= 14'sd1536;
      thick_hi_q <= 14'sd1792;
      thin_lo_q  <= 14'sd1638;
      thin_hi_q  <= 14'sd1690;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        eph_pkg::CFG_SLICE_EN:   slice_en_q <= cfg_data_i[0];
        eph_pkg::CFG_THICK_Y_LO: thick_lo_q <= signed'(cfg_data_i);
        eph_pkg::CFG_THICK_Y_HI: thick_hi_q <= signed'(cfg_data_i);
        eph_pkg::CFG_THIN_Y_LO:  thin_lo_q  <= signed'(cfg_data_i);
        eph_pkg::CFG_THIN_Y_HI:  thin_hi_q  <= signed'(cfg_data_i);
        default: ;  // ignore unknown indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  eph_pkg::eph_state_e state_q, state_d;
  logic [CL_W-1:0]     clr_cnt_q, clr_cnt_d;
  logic                accept;
  logic                clearing;

  assign accept   = start_i && !busy_o;
  assign clearing = (state_q == eph_pkg::ST_CLEAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= eph_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    busy_o    = 1'b1;
    unique case (state_q)
      eph_pkg::ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == CL_W'(CLR_LEN - 1)) begin
          state_d = eph_pkg::ST_IDLE;
        end
      end
      eph_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          state_d = eph_pkg::ST_BIN;
        end
      end
      eph_pkg::ST_BIN:    state_d = eph_pkg::ST_CLAMP;
      eph_pkg::ST_CLAMP:  state_d = eph_pkg::ST_ADDR;
      eph_pkg::ST_ADDR:   state_d = eph_pkg::ST_UPDATE;
      eph_pkg::ST_UPDATE: state_d = eph_pkg::ST_IDLE;
      default:            state_d = eph_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage 1: qualify the event, form the bin numerators
  // ---------------------------------------------------------------------------
  logic                        s1_func;
  logic [eph_pkg::TBL_W-1:0]   s1_sel;
  logic [7:0]                  s1_row;
  logic [5:0]                  s1_col;
  logic                        s1_rd_ok, s1_dq, s1_kq, s1_nq;
  logic [DV_W-1:0]             s1_dv;
  logic                        s1_kx_neg, s1_kz_neg, s1_nx_neg, s1_nz_neg;
  logic [SV_W-1:0]             s1_kx_v, s1_kz_v, s1_nx_v, s1_nz_v;

  logic                        is_event, d_in, k_in, n_in, rd_ok;
  logic [eph_pkg::DD_W-1:0]    dd;
  logic [DNUM_W-1:0]           dnum;
  logic signed [SN_W-1:0]      kx_num, kz_num, nx_num, nz_num;

  always_comb begin
    is_event = (func_i == eph_pkg::FUNC_EVENT);
    d_in = (pos_x_i >= -eph_pkg::XZ_LIM) && (pos_x_i <= eph_pkg::XZ_LIM) &&
           (pos_z_i >= -eph_pkg::XZ_LIM) && (pos_z_i <= eph_pkg::XZ_LIM) &&
           (pos_y_i >= -eph_pkg::Y_LIM)  && (pos_y_i <= eph_pkg::Y_LIM);
    k_in = slice_en_q && (pos_y_i >= thick_lo_q) && (pos_y_i < thick_hi_q);
    n_in = slice_en_q && (pos_y_i >= thin_lo_q) && (pos_y_i < thin_hi_q);
    // 2560 - y lies in 0..5120 whenever the depth cut passes
    dd   = eph_pkg::DD_W'(eph_pkg::Y_LIM - pos_y_i);
    dnum = DNUM_W'(dd) * DNUM_W'(DEPTH_BINS);
    kx_num = slice_num(pos_x_i, THICK_BINS);
    kz_num = slice_num(pos_z_i, THICK_BINS);
    nx_num = slice_num(pos_x_i, THIN_BINS);
    nz_num = slice_num(pos_z_i, THIN_BINS);
    rd_ok = 1'b0;
    unique case (table_sel_i)
      eph_pkg::TBL_DEPTH: rd_ok = int'(row_index_i) < DEPTH_BINS;
      eph_pkg::TBL_THICK: rd_ok = (int'(row_index_i) < THICK_BINS) &&
                                  (int'(col_index_i) < THICK_BINS);
      eph_pkg::TBL_THIN:  rd_ok = (int'(row_index_i) < THIN_BINS) &&
                                  (int'(col_index_i) < THIN_BINS);
      default:            rd_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func   <= func_i;
      s1_sel    <= table_sel_i;
      s1_row    <= row_index_i;
      s1_col    <= col_index_i;
      s1_rd_ok  <= !is_event && rd_ok;
      s1_dq     <= is_event && d_in;
      s1_kq     <= is_event && k_in;
      s1_nq     <= is_event && n_in;
      s1_dv     <= dnum[DNUM_W-1:eph_pkg::DEPTH_SHIFT];
      s1_kx_neg <= kx_num[SN_W-1];
      s1_kz_neg <= kz_num[SN_W-1];
      s1_nx_neg <= nx_num[SN_W-1];
      s1_nz_neg <= nz_num[SN_W-1];
      s1_kx_v   <= kx_num[SN_W-2:eph_pkg::SLICE_SHIFT];
      s1_kz_v   <= kz_num[SN_W-2:eph_pkg::SLICE_SHIFT];
      s1_nx_v   <= nx_num[SN_W-2:eph_pkg::SLICE_SHIFT];
      s1_nz_v   <= nz_num[SN_W-2:eph_pkg::SLICE_SHIFT];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: divide by five and clamp, or take the read indexes
  // ---------------------------------------------------------------------------
  logic [eph_pkg::TBL_W-1:0]   s2_sel;
  logic                        s2_rd_ok, s2_dq, s2_kq, s2_nq;
  logic [DA_W-1:0]             s2_dbin;
  logic [KB_W-1:0]             s2_kx, s2_kz;
  logic [NB_W-1:0]             s2_nx, s2_nz;

  logic [eph_pkg::DIV_W-1:0]   dq5;

  always_comb begin
    dq5 = eph_pkg::div5(eph_pkg::DIV_W'(s1_dv));
    if (dq5 > eph_pkg::DIV_W'(DEPTH_BINS - 1)) begin
      dq5 = eph_pkg::DIV_W'(DEPTH_BINS - 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == eph_pkg::ST_BIN) begin
      s2_sel   <= s1_sel;
      s2_rd_ok <= s1_rd_ok;
      s2_dq    <= s1_dq;
      s2_kq    <= s1_kq;
      s2_nq    <= s1_nq;
      if (s1_func == eph_pkg::FUNC_READ) begin
        s2_dbin <= DA_W'(s1_row);
        s2_kx   <= KB_W'(s1_row);
        s2_kz   <= KB_W'(s1_col);
        s2_nx   <= NB_W'(s1_row);
        s2_nz   <= NB_W'(s1_col);
      end else begin
        s2_dbin <= DA_W'(dq5);
        s2_kx   <= KB_W'(slice_bin(s1_kx_neg, s1_kx_v, THICK_BINS));
        s2_kz   <= KB_W'(slice_bin(s1_kz_neg, s1_kz_v, THICK_BINS));
        s2_nx   <= NB_W'(slice_bin(s1_nx_neg, s1_nx_v, THIN_BINS));
        s2_nz   <= NB_W'(slice_bin(s1_nz_neg, s1_nz_v, THIN_BINS));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: form memory addresses and read the counters
  // ---------------------------------------------------------------------------
  logic                        s3_rd_ok, s3_dq, s3_kq, s3_nq;
  logic [eph_pkg::TBL_W-1:0]   s3_sel;
  logic [DA_W-1:0]             s3_daddr;
  logic [KA_W-1:0]             s3_kaddr;
  logic [NA_W-1:0]             s3_naddr;

  logic [KA_W-1:0]             k_addr;
  logic [NA_W-1:0]             n_addr;
  logic                        rd_en;

  assign k_addr = KA_W'(KA_W'(s2_kx) * KA_W'(THICK_BINS) + KA_W'(s2_kz));
  assign n_addr = NA_W'(NA_W'(s2_nx) * NA_W'(THIN_BINS) + NA_W'(s2_nz));
  assign rd_en  = (state_q == eph_pkg::ST_ADDR);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s3_rd_ok <= s2_rd_ok;
      s3_sel   <= s2_sel;
      s3_dq    <= s2_dq;
      s3_kq    <= s2_kq;
      s3_nq    <= s2_nq;
      s3_daddr <= s2_dbin;
      s3_kaddr <= k_addr;
      s3_naddr <= n_addr;
    end
  end

  // ---------------------------------------------------------------------------
  // Counter memories: zero during the clearing pass, else write back the bump
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] depth_mem [DEPTH_BINS];
  logic [COUNT_WIDTH-1:0] thick_mem [THICK_SIZE];
  logic [COUNT_WIDTH-1:0] thin_mem  [THIN_SIZE];

  logic [COUNT_WIDTH-1:0] d_rdata_q, k_rdata_q, n_rdata_q;
  logic [COUNT_WIDTH-1:0] d_wdata, k_wdata, n_wdata;
  logic [DA_W-1:0]        d_waddr;
  logic [KA_W-1:0]        k_waddr;
  logic [NA_W-1:0]        n_waddr;
  logic                   d_we, k_we, n_we, upd;

  assign upd = (state_q == eph_pkg::ST_UPDATE);

  always_comb begin
    if (clearing) begin
      d_we    = clr_cnt_q < CL_W'(DEPTH_BINS);
      k_we    = clr_cnt_q < CL_W'(THICK_SIZE);
      n_we    = clr_cnt_q < CL_W'(THIN_SIZE);
      d_waddr = clr_cnt_q[DA_W-1:0];
      k_waddr = clr_cnt_q[KA_W-1:0];
      n_waddr = clr_cnt_q[NA_W-1:0];
      d_wdata = '0;
      k_wdata = '0;
      n_wdata = '0;
    end else begin
      d_we    = upd && s3_dq;
      k_we    = upd && s3_kq;
      n_we    = upd && s3_nq;
      d_waddr = s3_daddr;
      k_waddr = s3_kaddr;
      n_waddr = s3_naddr;
      // hold at the top value once saturated
      d_wdata = (&d_rdata_q) ? d_rdata_q : d_rdata_q + 1'b1;
      k_wdata = (&k_rdata_q) ? k_rdata_q : k_rdata_q + 1'b1;
      n_wdata = (&n_rdata_q) ? n_rdata_q : n_rdata_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_we) begin
      depth_mem[d_waddr] <= d_wdata;
    end
    if (rd_en) begin
      d_rdata_q <= depth_mem[s2_dbin];
    end
  end

  always_ff @(posedge clk_i) begin
    if (k_we) begin
      thick_mem[k_waddr] <= k_wdata;
    end
    if (rd_en) begin
      k_rdata_q <= thick_mem[k_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_we) begin
      thin_mem[n_waddr] <= n_wdata;
    end
    if (rd_en) begin
      n_rdata_q <= thin_mem[n_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: one strobe per item
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] rd_data;

  always_comb begin
    rd_data = '0;
    if (s3_rd_ok) begin
      unique case (s3_sel)
        eph_pkg::TBL_DEPTH: rd_data = d_rdata_q;
        eph_pkg::TBL_THICK: rd_data = k_rdata_q;
        eph_pkg::TBL_THIN:  rd_data = n_rdata_q;
        default:            rd_data = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      depth_hit_o  <= s3_dq;
      depth_bin_o  <= s3_dq ? 8'(s3_daddr) : 8'd0;
      thick_hit_o  <= s3_kq;
      thin_hit_o   <= s3_nq;
      read_count_o <= 32'(rd_data[RC_W-1:0]);
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/event_position_histogrammer_test.sv
module event_position_histogrammer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH_BINS  = 200;
  localparam int THICK_BINS  = 10;
  localparam int THIN_BINS   = 50;
  localparam int COUNT_WIDTH = 32;

  // Widths and codes shared with the block
  localparam int POS_W      = eph_pkg::POS_W;
  localparam int TBL_W      = eph_pkg::TBL_W;
  localparam int CFG_IDX_W  = eph_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = eph_pkg::CFG_DATA_W;

  localparam logic FUNC_EVENT = eph_pkg::FUNC_EVENT;
  localparam logic FUNC_READ  = eph_pkg::FUNC_READ;

  localparam logic [TBL_W-1:0] TBL_DEPTH = eph_pkg::TBL_DEPTH;
  localparam logic [TBL_W-1:0] TBL_THICK = eph_pkg::TBL_THICK;
  localparam logic [TBL_W-1:0] TBL_THIN  = eph_pkg::TBL_THIN;

  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_EN   = eph_pkg::CFG_SLICE_EN;
  localparam logic [CFG_IDX_W-1:0] CFG_THICK_Y_LO = eph_pkg::CFG_THICK_Y_LO;
  localparam logic [CFG_IDX_W-1:0] CFG_THICK_Y_HI = eph_pkg::CFG_THICK_Y_HI;
  localparam logic [CFG_IDX_W-1:0] CFG_THIN_Y_LO  = eph_pkg::CFG_THIN_Y_LO;
  localparam logic [CFG_IDX_W-1:0] CFG_THIN_Y_HI  = eph_pkg::CFG_THIN_Y_HI;

  // Table code that selects no histogram; reads through it return zero.
  localparam logic [TBL_W-1:0] TBL_NONE = 2'd3;

  // Geometry in 1/256 cm: depth acceptance box and slice span offset.
  localparam int XZ_MAX     = 512;
  localparam int Y_MAX      = 2560;
  localparam int SLICE_OFF  = 1280;
  localparam int SLICE_SPAN = 2560;
  localparam int POS_MIN    = -8192;
  localparam int POS_MAX    = 8191;

  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 235;
  localparam int QUIET_PHASE = 5;    // phase run back to back with no sender gaps
  localparam int REPORT_MAX  = 10;
  localparam int TAIL_CYCLES = 10;   // extra settle time after the last result
  localparam int DRAIN_LIMIT = 1000;

  typedef struct packed {
    logic             func;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic [TBL_W-1:0] sel;
    logic [7:0]       row;
    logic [5:0]       col;
  } hist_cmd_t;

  typedef struct packed {
    logic        depth_hit;
    logic [7:0]  depth_bin;
    logic        thick_hit;
    logic        thin_hit;
    logic [31:0] count;
  } hist_result_t;

  // One line of the directed plan: the item, and its result when it is obvious.
  typedef struct packed {
    hist_cmd_t    cmd;
    logic         fixed;
    hist_result_t res;
  } hist_row_t;

  localparam hist_result_t NO_HIT = '0;

  localparam hist_row_t DIRECTED [26] = '{
    // reads right after the clearing pass see empty stores
    '{'{FUNC_READ, 14'd0, 14'd0, 14'd0, TBL_DEPTH, 8'd0, 6'd0}, 1'b1, NO_HIT},
    '{'{FUNC_READ, 14'd0, 14'd0, 14'd0, TBL_THIN, 8'd49, 6'd49}, 1'b1, NO_HIT},
    '{'{FUNC_READ, 14'd0, 14'd0, 14'd0, TBL_NONE, 8'd0, 6'd0}, 1'b1, NO_HIT},
    // depth box center, far edge (clamped to the top bin) and near edge
    '{'{FUNC_EVENT, 14'd0, 14'd0, 14'd0, TBL_THICK, 8'd255, 6'd63}, 1'b1,
      '{1'b1, 8'd100, 1'b0, 1'b0, 32'd0}},
    '{'{FUNC_EVENT, 14'd512, -14'sd2560, -14'sd512, TBL_DEPTH, 8'd0, 6'd0}, 1'b1,
      '{1'b1, 8'd199, 1'b0, 1'b0, 32'd0}},
    '{'{FUNC_EVENT, -14'sd512, 14'd2560, 14'd512, TBL_DEPTH, 8'd0, 6'd0}, 1'b1,
      '{1'b1, 8'd0, 1'b0, 1'b0, 32'd0}},
    // one step outside the depth box
    '{'{FUNC_EVENT, 14'd513, 14'd0, 14'd0, TBL_DEPTH, 8'd0, 6'd0}, 1'b1, NO_HIT},
    '{'{FUNC_EVENT, 14'd0, 14'd2561, -14'sd513, TBL_DEPTH, 8'd0, 6'd0}, 1'b1, NO_HIT},
    // slice window edges and clamping of the x and z bins
    '{'{FUNC_EVENT, 14'h2000, 14'd1536, 14'd8191, TBL_DEPTH, 8'd0, 6'd0}, 1'b0, NO_HIT},
    '{'{FUNC_EVENT, 14'd8191, 14'd1791, 14'h2000, TBL_DEPTH, 8'd0, 6'd0}, 1'b0, NO_HIT},
    '{'{FUNC_EVENT, -14'sd1280, 14'd1638, 14'd1279, TBL_DEPTH, 8'd0, 6'd0}, 1'b0, NO_HIT},
    '{'{FUNC_EVENT, -14'sd1281, 14'd1689, -14'sd1, TBL_DEPTH, 8'd0, 6'd0}, 1'b0, NO_HIT},
    '{'{FUNC_EVENT, 14'd0, 14'd1690, 14'd0, TBL_DEPTH, 8'd0, 6'd0}, 1'b0, NO_HIT},
    '{'{FUNC_EVENT, 14'd0, 14'd1535, 14'd0, TBL_DEPTH, 8'd0, 6'd0}, 1'b0, NO_HIT},
    // position extremes land nowhere under the reset windows
    '{'{FUNC_EVENT, 14'h2000, 14'h2000, 14'h2000, TBL_DEPTH, 8'd0, 6'd0}, 1'b1, NO_HIT},
    '{'{FUNC_EVENT, 14'd8191, 14'd8191, 14'd8191, TBL_DEPTH, 8'd0, 6'd0}, 1'b1, NO_HIT},
    // read back what was counted, plus indexes past each table
    '{'{FUNC_READ, -14'sd1, -14'sd1, -14'sd1, TBL_DEPTH, 8'd100, 6'd63}, 1'b0, NO_HIT},
    '{'{FUNC_READ, 14'd0, 14'd0, 14'd0, TBL_DEPTH, 8'd199, 6'd0}, 1'b0, NO_HIT},
    '{'{FUNC_READ, 14'd0, 14'd0, 14'd0, TBL_DEPTH, 8'd200, 6'd0}, 1'b1, NO_HIT},
    '{'{FUNC_READ, 14'd0, 14'd0, 14'd0, TBL_DEPTH, 8'd255, 6'd0}, 1'b1, NO_HIT},
    '{'{FUNC_READ, 14'd0, 14'd0, 14'd0, TBL_THICK, 8'd9, 6'd9}, 1'b0, NO_HIT},
    '{'{FUNC_READ, 14'd0, 14'd0, 14'd0, TBL_THICK, 8'd0, 6'd9}, 1'b0, NO_HIT},
    '{'{FUNC_READ, 14'd0, 14'd0, 14'd0, TBL_THICK, 8'd10, 6'd0}, 1'b1, NO_HIT},
    '{'{FUNC_READ, 14'd0, 14'd0, 14'd0, TBL_THIN, 8'd0, 6'd49}, 1'b0, NO_HIT},
    '{'{FUNC_READ, 14'd0, 14'd0, 14'd0, TBL_THIN, 8'd0, 6'd50}, 1'b1, NO_HIT},
    '{'{FUNC_READ, 14'd0, 14'd0, 14'd0, TBL_NONE, 8'd255, 6'd63}, 1'b1, NO_HIT}
  };

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  start_i     = 1'b0;
  logic                  func_i      = FUNC_EVENT;
  logic [POS_W-1:0]      pos_x_i     = '0;
  logic [POS_W-1:0]      pos_y_i     = '0;
  logic [POS_W-1:0]      pos_z_i     = '0;
  logic [TBL_W-1:0]      table_sel_i = TBL_DEPTH;
  logic [7:0]            row_index_i = '0;
  logic [5:0]            col_index_i = '0;

  logic        busy_o;
  logic        done_o;
  logic        depth_hit_o;
  logic [7:0]  depth_bin_o;
  logic        thick_hit_o;
  logic        thin_hit_o;
  logic [31:0] read_count_o;

  event_position_histogrammer #(
    .DEPTH_BINS (DEPTH_BINS),
    .THICK_BINS (THICK_BINS),
    .THIN_BINS  (THIN_BINS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .table_sel_i (table_sel_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .done_o      (done_o),
    .depth_hit_o (depth_hit_o),
    .depth_bin_o (depth_bin_o),
    .thick_hit_o (thick_hit_o),
    .thin_hit_o  (thin_hit_o),
    .read_count_o(read_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the clearing pass plus every item at its slowest.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Shadow of the histogram stores and the slice windows.
  logic [COUNT_WIDTH-1:0] depth_tally [DEPTH_BINS];
  logic [COUNT_WIDTH-1:0] thick_tally [THICK_BINS*THICK_BINS];
  logic [COUNT_WIDTH-1:0] thin_tally  [THIN_BINS*THIN_BINS];
  logic                   slice_on;
  logic [POS_W-1:0]       thick_lo, thick_hi, thin_lo, thin_hi;

  hist_result_t awaited_results [$];
  hist_result_t oldest;
  int           errors = 0;
  bit           idle_on = 1'b1;

  // Counters stick at all ones.
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // floor(n*(p+1280)/2560), held to 0..n-1
  function automatic int slice_bin(input int p, input int n);
    int num;
    num = n * (p + SLICE_OFF);
    if (num < 0) return 0;
    return (num / SLICE_SPAN > n - 1) ? n - 1 : num / SLICE_SPAN;
  endfunction

  // Record an event into the shadow stores or fetch one counter; return the
  // result the block must show for this item.
  function automatic hist_result_t histogram_update(input hist_cmd_t c);
    hist_result_t r;
    int x, y, z, b, k;
    r = '0;
    x = int'($signed(c.x));
    y = int'($signed(c.y));
    z = int'($signed(c.z));
    if (c.func == FUNC_EVENT) begin
      if (x >= -XZ_MAX && x <= XZ_MAX && z >= -XZ_MAX && z <= XZ_MAX &&
          y >= -Y_MAX && y <= Y_MAX) begin
        b = DEPTH_BINS * (Y_MAX - y) / (2 * Y_MAX);
        if (b > DEPTH_BINS - 1) b = DEPTH_BINS - 1;
        depth_tally[b] = sat_inc(depth_tally[b]);
        r.depth_hit = 1'b1;
        r.depth_bin = 8'(b);
      end
      if (slice_on) begin
        if (y >= int'($signed(thick_lo)) && y < int'($signed(thick_hi))) begin
          k = slice_bin(x, THICK_BINS) * THICK_BINS + slice_bin(z, THICK_BINS);
          thick_tally[k] = sat_inc(thick_tally[k]);
          r.thick_hit = 1'b1;
        end
        if (y >= int'($signed(thin_lo)) && y < int'($signed(thin_hi))) begin
          k = slice_bin(x, THIN_BINS) * THIN_BINS + slice_bin(z, THIN_BINS);
          thin_tally[k] = sat_inc(thin_tally[k]);
          r.thin_hit = 1'b1;
        end
      end
    end else begin
      case (c.sel)
        TBL_DEPTH: begin
          if (c.row < DEPTH_BINS) r.count = 32'(depth_tally[c.row]);
        end
        TBL_THICK: begin
          if (c.row < THICK_BINS && c.col < THICK_BINS)
            r.count = 32'(thick_tally[c.row * THICK_BINS + c.col]);
        end
        TBL_THIN: begin
          if (c.row < THIN_BINS && c.col < THIN_BINS)
            r.count = 32'(thin_tally[c.row * THIN_BINS + c.col]);
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Uniform pick in [lo, hi], kept inside the 14-bit position range.
  function automatic logic [POS_W-1:0] span(input int lo, input int hi);
    int t;
    if (hi < lo) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    if (lo < POS_MIN) lo = POS_MIN;
    if (hi > POS_MAX) hi = POS_MAX;
    return POS_W'(lo + int'($urandom_range(hi - lo)));
  endfunction

  // Mostly near the depth box or the slice span, sometimes anywhere.
  function automatic logic [POS_W-1:0] pick_xz();
    int r;
    r = $urandom_range(99);
    if (r < 50) return span(-XZ_MAX - 28, XZ_MAX + 28);
    if (r < 80) return span(-SLICE_OFF - 120, SLICE_OFF + 120);
    return POS_W'($urandom);
  endfunction

  function automatic hist_cmd_t rand_cmd();
    hist_cmd_t c;
    int pick;
    c.func = ($urandom_range(99) < 30) ? FUNC_READ : FUNC_EVENT;
    c.x    = pick_xz();
    c.z    = pick_xz();
    c.sel  = TBL_W'($urandom);
    c.row  = 8'($urandom);
    c.col  = 6'($urandom);
    // aim y at the window edges so the inclusive and exclusive bounds get hit
    pick = $urandom_range(99);
    if (pick < 25)
      c.y = span(int'($signed(thick_lo)) - 4, int'($signed(thick_hi)) + 4);
    else if (pick < 45)
      c.y = span(int'($signed(thin_lo)) - 4, int'($signed(thin_hi)) + 4);
    else if (pick < 75)
      c.y = span(-Y_MAX - 40, Y_MAX + 40);
    else
      c.y = POS_W'($urandom);
    if (c.func == FUNC_READ && $urandom_range(99) < 90) begin
      // keep most reads inside the selected table
      pick = $urandom_range(99);
      if (pick < 30) begin
        c.sel = TBL_DEPTH;
        c.row = 8'($urandom_range(DEPTH_BINS - 1));
      end else if (pick < 60) begin
        c.sel = TBL_THICK;
        c.row = 8'($urandom_range(THICK_BINS - 1));
        c.col = 6'($urandom_range(THICK_BINS - 1));
      end else if (pick < 96) begin
        c.sel = TBL_THIN;
        c.row = 8'($urandom_range(THIN_BINS - 1));
        c.col = 6'($urandom_range(THIN_BINS - 1));
      end else begin
        c.sel = TBL_NONE;
      end
    end
    return c;
  endfunction

  // Present one item, hold it until the block takes it, then log its result.
  // start_i stays high on return so a back-to-back item needs no toggle.
  // A gap is counted in cycles where the block could take an item.
  task automatic issue(input hist_cmd_t c, input logic fixed, input hist_result_t res);
    hist_result_t r;
    if (idle_on && $urandom_range(99) < 24) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while (busy_o);
      repeat ($urandom_range(0, 5)) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    func_i      <= c.func;
    pos_x_i     <= c.x;
    pos_y_i     <= c.y;
    pos_z_i     <= c.z;
    table_sel_i <= c.sel;
    row_index_i <= c.row;
    col_index_i <= c.col;
    do @(posedge clk_i); while (busy_o);
    r = histogram_update(c);
    awaited_results.push_back(fixed ? res : r);
  endtask

  // Drop start and wait out every outstanding result plus the latency.
  task automatic settle();
    int waited;
    waited = 0;
    start_i <= 1'b0;
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // One register write; the write enable is left high for the next one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SLICE_EN:   slice_on = data[0];
      CFG_THICK_Y_LO: thick_lo = data;
      CFG_THICK_Y_HI: thick_hi = data;
      CFG_THIN_Y_LO:  thin_lo  = data;
      CFG_THIN_Y_HI:  thin_hi  = data;
      default: ;
    endcase
  endtask

  // Load all window registers; slip a write to an unused index in between,
  // which must leave everything as it was. Upper enable bits carry noise.
  task automatic set_windows(input logic en, input int tl, input int th,
                             input int nl, input int nh);
    write_reg(CFG_SLICE_EN, {13'($urandom), en});
    write_reg(CFG_THICK_Y_LO, CFG_DATA_W'(tl));
    write_reg(CFG_THICK_Y_HI, CFG_DATA_W'(th));
    write_reg(CFG_THIN_Y_HI + CFG_IDX_W'($urandom_range(1, 3)), CFG_DATA_W'($urandom));
    write_reg(CFG_THIN_Y_LO, CFG_DATA_W'(nl));
    write_reg(CFG_THIN_Y_HI, CFG_DATA_W'(nh));
    cfg_we_i <= 1'b0;
  endtask

  // Check each strobed result against the oldest logged one.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result: hit=%0d bin=%0d thick=%0d thin=%0d count=%0d",
                   depth_hit_o, depth_bin_o, thick_hit_o, thin_hit_o, read_count_o);
      end else begin
        oldest = awaited_results.pop_front();
        if (oldest.depth_hit !== depth_hit_o || oldest.depth_bin !== depth_bin_o ||
            oldest.thick_hit !== thick_hit_o || oldest.thin_hit !== thin_hit_o ||
            oldest.count !== read_count_o) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("mismatch: want hit=%0d bin=%0d thick=%0d thin=%0d count=%0d,",
                     oldest.depth_hit, oldest.depth_bin, oldest.thick_hit,
                     oldest.thin_hit, oldest.count,
                     " got %0d %0d %0d %0d %0d", depth_hit_o, depth_bin_o,
                     thick_hit_o, thin_hit_o, read_count_o);
        end
      end
    end
  end

  initial begin : stimulus
    int tl, nl;
    // Mirror the reset state: empty stores and the default windows.
    foreach (depth_tally[i]) depth_tally[i] = '0;
    foreach (thick_tally[i]) thick_tally[i] = '0;
    foreach (thin_tally[i])  thin_tally[i]  = '0;
    slice_on = 1'b1;
    thick_lo = 14'd1536;
    thick_hi = 14'd1792;
    thin_lo  = 14'd1638;
    thin_hi  = 14'd1690;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed plan under the reset windows; the clearing pass holds busy.
    foreach (DIRECTED[i])
      issue(DIRECTED[i].cmd, DIRECTED[i].fixed, DIRECTED[i].res);
    // Hold off completely until every result is back.
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: set_windows(1'b1, 1536, 1792, 1638, 1690);
        1: set_windows(1'b1, POS_MIN, POS_MAX, -Y_MAX, Y_MAX);
        2: set_windows(1'b0, -Y_MAX, Y_MAX, -1000, 1000);      // slices off
        3: set_windows(1'b1, POS_MAX, POS_MIN, 0, 0);          // empty windows
        4: set_windows(1'b1, POS_MAX - 1, POS_MAX, POS_MIN, POS_MIN + 1);
        default: begin
          tl = $urandom_range(5000) - 3000;
          nl = $urandom_range(5000) - 3000;
          set_windows($urandom_range(99) < 85, tl, tl + int'($urandom_range(1500)),
                      nl, nl + int'($urandom_range(400)));
        end
      endcase
      idle_on = (ph != QUIET_PHASE);
      for (int i = 0; i < PHASE_ITEMS; i++)
        issue(rand_cmd(), 1'b0, NO_HIT);
      settle();
    end

    errors += awaited_results.size();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
rtl/core/eph_pkg.sv
rtl/core/event_position_histogrammer.sv
tb/sv/event_position_histogrammer_test.sv
